>>> design/brsc_pkg.sv
// Shared constants, types and codes for the Banker's request safety checker.
package brsc_pkg;

  // Table geometry.
  localparam int PROCS     = 5;
  localparam int RESOURCES = 3;

  // Index and counter widths derived from the geometry.
  localparam int PIDX_W = (PROCS > 1) ? $clog2(PROCS) : 1;
  localparam int RIDX_W = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
  localparam int SLOT_W = $clog2(PROCS + 1);

  // Field widths of the channels.
  localparam int CNT_W       = 8;
  localparam int STATUS_W    = 3;
  localparam int ORDER_SLOTS = 5;
  localparam int ORDER_W     = 3 * ORDER_SLOTS;

  // Sized bounds for range checks on the item fields.
  localparam logic [3:0] PROC_CNT = 4'(PROCS);
  localparam logic [3:0] RES_CNT  = 4'(RESOURCES);

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [PIDX_W-1:0] pidx_t;

  // Item modes.
  typedef enum logic [1:0] {
    MODE_CLAIM,
    MODE_HELD,
    MODE_AVAIL,
    MODE_REQUEST
  } mode_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_LOAD_DONE,
    ST_GRANTED,
    ST_EXCEEDS,
    ST_NOT_AVAIL,
    ST_UNSAFE
  } status_t;

  // Datapath actions issued by the microcode.
  typedef enum logic [3:0] {
    A_TAKE,
    A_NOP,
    A_CHECK,
    A_GRANT,
    A_SCAN,
    A_ROLLBACK,
    A_SAFE,
    A_LOAD,
    A_EMIT
  } act_t;

  // Condition flags reported by the datapath to the sequencer.
  typedef struct packed {
    logic in_fire;
    logic is_load;
    logic refuse;
    logic scan_more;
    logic all_done;
    logic out_busy;
  } flags_t;

endpackage

>>> design/brsc_in_if.sv
// Input channel interface: load and request items.
interface brsc_in_if;
  import brsc_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       mode;
  logic [2:0]       process;
  logic [1:0]       resource;
  logic [CNT_W-1:0] value;
  logic [CNT_W-1:0] req_first;
  logic [CNT_W-1:0] req_second;
  logic [CNT_W-1:0] req_third;

  modport source (
    output valid, mode, process, resource, value, req_first, req_second, req_third,
    input  ready
  );

  modport sink (
    input  valid, mode, process, resource, value, req_first, req_second, req_third,
    output ready
  );
endinterface

>>> design/brsc_out_if.sv
// Result channel interface: status and safe order.
interface brsc_out_if;
  import brsc_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ORDER_W-1:0]  safe_order;

  modport source (
    output valid, status, safe_order,
    input  ready
  );

  modport sink (
    input  valid, status, safe_order,
    output ready
  );
endinterface

>>> design/brsc_useq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
module brsc_useq (
  input  logic            clk,
  input  logic            rst_n,
  input  brsc_pkg::flags_t flags,
  output brsc_pkg::act_t   act
);
  import brsc_pkg::*;

  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  // Jump conditions.
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_IS_LOAD,
    C_REFUSE,
    C_SCAN_MORE,
    C_ALL_DONE,
    C_OUT_BUSY
  } cond_t;

  // One control word.
  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  target;
    logic  last;
  } uword_t;

  // Step addresses.
  localparam upc_t U_IDLE   = 4'd0;
  localparam upc_t U_DISP   = 4'd1;
  localparam upc_t U_CHECK  = 4'd2;
  localparam upc_t U_GRANT  = 4'd3;
  localparam upc_t U_SCAN   = 4'd4;
  localparam upc_t U_DECIDE = 4'd5;
  localparam upc_t U_ROLL   = 4'd6;
  localparam upc_t U_SAFE   = 4'd7;
  localparam upc_t U_LOAD   = 4'd8;
  localparam upc_t U_EMIT   = 4'd9;

  // Control store.
  function automatic uword_t urom(upc_t addr);
    uword_t w;
    unique case (addr)
      U_IDLE:   w = '{A_TAKE,     C_NO_ACCEPT, U_IDLE,  1'b0};
      U_DISP:   w = '{A_NOP,      C_IS_LOAD,   U_LOAD,  1'b0};
      U_CHECK:  w = '{A_CHECK,    C_REFUSE,    U_EMIT,  1'b0};
      U_GRANT:  w = '{A_GRANT,    C_NEVER,     U_IDLE,  1'b0};
      U_SCAN:   w = '{A_SCAN,     C_SCAN_MORE, U_SCAN,  1'b0};
      U_DECIDE: w = '{A_NOP,      C_ALL_DONE,  U_SAFE,  1'b0};
      U_ROLL:   w = '{A_ROLLBACK, C_ALWAYS,    U_EMIT,  1'b0};
      U_SAFE:   w = '{A_SAFE,     C_ALWAYS,    U_EMIT,  1'b0};
      U_LOAD:   w = '{A_LOAD,     C_NEVER,     U_IDLE,  1'b0};
      U_EMIT:   w = '{A_EMIT,     C_OUT_BUSY,  U_EMIT,  1'b1};
      default:  w = '{A_NOP,      C_ALWAYS,    U_IDLE,  1'b0};
    endcase
    return w;
  endfunction

  upc_t   upc_r;
  upc_t   upc_nxt;
  uword_t uw;
  logic   hit;

  // Decode the current word and evaluate its jump condition.
  always_comb begin
    uw = urom(upc_r);
    unique case (uw.cond)
      C_NEVER:     hit = 1'b0;
      C_ALWAYS:    hit = 1'b1;
      C_NO_ACCEPT: hit = !flags.in_fire;
      C_IS_LOAD:   hit = flags.is_load;
      C_REFUSE:    hit = flags.refuse;
      C_SCAN_MORE: hit = flags.scan_more;
      C_ALL_DONE:  hit = flags.all_done;
      C_OUT_BUSY:  hit = flags.out_busy;
      default:     hit = 1'b0;
    endcase
  end

  // Next step: jump target, return to idle after the last step, else the next word.
  always_comb begin
    if (hit) begin
      upc_nxt = uw.target;
    end else if (uw.last) begin
      upc_nxt = U_IDLE;
    end else begin
      upc_nxt = upc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign act = uw.act;

endmodule

>>> design/bankers_request_safety_check.sv
// Banker's algorithm request checker: top level with the datapath.
//
// Usage: every transaction on in_ch is one item. Modes claim, held and available
// write one entry of the claim table, the held table or the available vector and
// return status "load done". A request item asks for req_first, req_second and
// req_third units for one process. It is refused (exceeds claim or not available)
// if any amount tops the remaining need or the available units, checked from
// resource 0 up. Otherwise it is granted tentatively and the safety scan runs;
// a safe grant returns the safe order, an unsafe one is rolled back.
// Each item gives exactly one transaction on out_ch.
// Timing: the block takes one item at a time. A load passes the dispatch, load and
// emit steps after acceptance, a refused request dispatch, check and emit, and a
// checked request dispatch, check, grant, the safety scan, decide, safe or
// rollback and emit. The safety scan visits one process per cycle for PROCS
// passes, PROCS * PROCS visits in all. After the result is registered the block
// returns to idle and takes the next item.
// Reset clears all tables to zero and leaves the block idle with no result.
// A stalled receiver holds the result in the output register; the block still
// takes and works the next item, and waits only to hand over its result.
module bankers_request_safety_check (
  input logic clk,
  input logic rst_n,
  brsc_in_if.sink    in_ch,
  brsc_out_if.source out_ch
);
  import brsc_pkg::*;

  // Sequencer interface.
  act_t   act;
  flags_t flags;

  // Latched item.
  mode_t item_mode_r;
  logic [2:0] item_proc_r;
  logic [1:0] item_res_r;
  cnt_t       item_val_r;
  logic [RESOURCES-1:0][CNT_W-1:0] req_r;

  // Architectural tables.
  logic [RESOURCES-1:0][CNT_W-1:0]             avail_r;
  logic [PROCS-1:0][RESOURCES-1:0][CNT_W-1:0]  claim_r;
  logic [PROCS-1:0][RESOURCES-1:0][CNT_W-1:0]  held_r;

  // Safety scan state.
  logic [RESOURCES-1:0][CNT_W-1:0] work_r;
  logic [PROCS-1:0]                done_r;
  pidx_t                           p_r;
  pidx_t                           pass_r;
  logic [SLOT_W-1:0]               slot_r;
  logic [ORDER_W-1:0]              order_r;
  status_t                         status_r;

  // Output register.
  logic               out_valid_r;
  status_t            out_status_r;
  logic [ORDER_W-1:0] out_order_r;

  // Combinational datapath signals.
  logic                            in_fire;
  logic                            out_busy;
  pidx_t                           item_pidx;
  pidx_t                           row_idx;
  logic [RESOURCES-1:0][CNT_W-1:0] row_claim;
  logic [RESOURCES-1:0][CNT_W-1:0] row_held;
  logic [RESOURCES-1:0][CNT_W-1:0] need;
  logic [RESOURCES-1:0][CNT_W-1:0] work_add;
  logic                            proc_ok;
  logic                            refuse;
  status_t                         refuse_code;
  logic                            fits;
  logic                            scan_last;
  logic [RIDX_W-1:0]               res_idx;
  logic [CNT_W:0]                  sum;

  brsc_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .act   (act)
  );

  // Handshake: no item is taken while reset is held.
  assign in_ch.ready = rst_n && (act == A_TAKE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_busy    = out_valid_r && !out_ch.ready;

  // One row of the tables is read per cycle: the scanned process or the requester.
  assign item_pidx = item_proc_r[PIDX_W-1:0];
  assign row_idx   = (act == A_SCAN) ? p_r : item_pidx;
  assign row_claim = claim_r[row_idx];
  assign row_held  = held_r[row_idx];
  assign res_idx   = RIDX_W'(item_res_r);
  assign proc_ok   = (4'(item_proc_r) < PROC_CNT);

  // Remaining need per resource, and saturating add-back of held units.
  always_comb begin
    sum = '0;
    for (int r = 0; r < RESOURCES; r++) begin
      need[r]     = (row_held[r] > row_claim[r]) ? '0 : row_claim[r] - row_held[r];
      sum         = {1'b0, work_r[r]} + {1'b0, row_held[r]};
      work_add[r] = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    end
  end

  // Request screening: the lowest failing resource decides, claim test first.
  always_comb begin
    refuse      = 1'b0;
    refuse_code = ST_EXCEEDS;
    for (int r = RESOURCES - 1; r >= 0; r--) begin
      if (req_r[r] > need[r]) begin
        refuse      = 1'b1;
        refuse_code = ST_EXCEEDS;
      end else if (req_r[r] > avail_r[r]) begin
        refuse      = 1'b1;
        refuse_code = ST_NOT_AVAIL;
      end
    end
    if (!proc_ok) begin
      refuse      = 1'b1;
      refuse_code = ST_EXCEEDS;
    end
  end

  // A process fits when it is unfinished and its whole need is covered.
  always_comb begin
    fits = !done_r[p_r];
    for (int r = 0; r < RESOURCES; r++) begin
      if (need[r] > work_r[r]) begin
        fits = 1'b0;
      end
    end
  end

  assign scan_last = (p_r == pidx_t'(PROCS - 1)) && (pass_r == pidx_t'(PROCS - 1));

  // Flags to the sequencer.
  always_comb begin
    flags.in_fire   = in_fire;
    flags.is_load   = (item_mode_r != MODE_REQUEST);
    flags.refuse    = refuse;
    flags.scan_more = !scan_last;
    flags.all_done  = &done_r;
    flags.out_busy  = out_busy;
  end

  // Tables and scan control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avail_r <= '0;
      claim_r <= '0;
      held_r  <= '0;
      done_r  <= '0;
      p_r     <= '0;
      pass_r  <= '0;
      slot_r  <= '0;
    end else begin
      case (act)
        A_LOAD: begin
          if (item_mode_r == MODE_AVAIL) begin
            if (4'(item_res_r) < RES_CNT) begin
              avail_r[res_idx] <= item_val_r;
            end
          end else if (proc_ok && (4'(item_res_r) < RES_CNT)) begin
            if (item_mode_r == MODE_CLAIM) begin
              claim_r[item_pidx][res_idx] <= item_val_r;
            end else begin
              held_r[item_pidx][res_idx] <= item_val_r;
            end
          end
        end
        A_GRANT: begin
          for (int r = 0; r < RESOURCES; r++) begin
            avail_r[r]            <= avail_r[r] - req_r[r];
            held_r[item_pidx][r]  <= held_r[item_pidx][r] + req_r[r];
          end
          done_r <= '0;
          p_r    <= '0;
          pass_r <= '0;
          slot_r <= '0;
        end
        A_SCAN: begin
          if (fits) begin
            done_r[p_r] <= 1'b1;
            slot_r      <= slot_r + 1'b1;
          end
          if (p_r == pidx_t'(PROCS - 1)) begin
            p_r    <= '0;
            pass_r <= pass_r + 1'b1;
          end else begin
            p_r <= p_r + 1'b1;
          end
        end
        A_ROLLBACK: begin
          for (int r = 0; r < RESOURCES; r++) begin
            avail_r[r]           <= avail_r[r] + req_r[r];
            held_r[item_pidx][r] <= held_r[item_pidx][r] - req_r[r];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Item capture, working units, order and status.
  always_ff @(posedge clk) begin
    case (act)
      A_TAKE: begin
        if (in_fire) begin
          item_mode_r <= mode_t'(in_ch.mode);
          item_proc_r <= in_ch.process;
          item_res_r  <= in_ch.resource;
          item_val_r  <= in_ch.value;
          for (int r = 0; r < RESOURCES; r++) begin
            if (r == 0) begin
              req_r[r] <= in_ch.req_first;
            end else if (r == 1) begin
              req_r[r] <= in_ch.req_second;
            end else if (r == 2) begin
              req_r[r] <= in_ch.req_third;
            end else begin
              req_r[r] <= '0;
            end
          end
        end
      end
      A_CHECK: begin
        status_r <= refuse_code;
      end
      A_GRANT: begin
        for (int r = 0; r < RESOURCES; r++) begin
          work_r[r] <= avail_r[r] - req_r[r];
        end
        order_r <= '0;
      end
      A_SCAN: begin
        if (fits) begin
          work_r <= work_add;
          for (int s = 0; s < ORDER_SLOTS; s++) begin
            if (int'(slot_r) == s) begin
              order_r[3*s +: 3] <= 3'(p_r);
            end
          end
        end
      end
      A_ROLLBACK: status_r <= ST_UNSAFE;
      A_SAFE:     status_r <= ST_GRANTED;
      A_LOAD:     status_r <= ST_LOAD_DONE;
      default: begin
      end
    endcase
  end

  // Output register: loaded when the previous result has left.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((act == A_EMIT) && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((act == A_EMIT) && !out_busy) begin
      out_status_r <= status_r;
      out_order_r  <= (status_r == ST_GRANTED) ? order_r : '0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.safe_order = out_order_r;

`ifndef NO_ASSERTIONS
  // A refused request leaves the tables untouched.
  a_refuse_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (act == A_CHECK && refuse) |=> ($stable(avail_r) && $stable(held_r)))
    else $error("refused request changed the tables");

  // A safe grant is declared only when every process finished.
  a_safe_all_done: assert property (@(posedge clk) disable iff (!rst_n)
    (act == A_SAFE) |-> (&done_r))
    else $error("safe grant with unfinished processes");

  // Every finished process took exactly one order slot.
  a_safe_slots: assert property (@(posedge clk) disable iff (!rst_n)
    (act == A_SAFE) |-> (int'(slot_r) == PROCS))
    else $error("slot count does not match process count");

  // Only a granted result carries an order.
  a_order_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_GRANTED) |-> (out_order_r == '0))
    else $error("order shown on a result that was not granted");
`endif

endmodule

>>> tb/sv/tb_bankers_request_safety_check.sv
// Testbench for the Banker's request safety checker: directed table, random traffic, scoreboard.
`timescale 1ns / 100ps

module tb_bankers_request_safety_check;
  import brsc_pkg::*;

  // One load or request item as it travels on the input channel.
  typedef struct packed {
    mode_t       mode;
    logic [2:0]  process;
    logic [1:0]  resource;
    cnt_t        value;
    cnt_t        req_first;
    cnt_t        req_second;
    cnt_t        req_third;
  } bank_item_t;

  // One result transaction.
  typedef struct packed {
    status_t            status;
    logic [ORDER_W-1:0] safe_order;
  } bank_result_t;

  // A row of the directed table; fixed rows carry a hand-written result.
  typedef struct packed {
    bank_item_t   item;
    logic         fixed;
    bank_result_t want;
  } plan_row_t;

  localparam logic [ORDER_W-1:0] ORDER_BY_INDEX = {3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
  localparam int TOTAL_ITEMS = 1750;

  logic clk;
  logic rst_n;

  brsc_in_if  in_ch ();
  brsc_out_if out_ch ();

  bankers_request_safety_check dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted copy of the block's tables.
  cnt_t pool_units  [RESOURCES];
  cnt_t claim_units [PROCS][RESOURCES];
  cnt_t held_units  [PROCS][RESOURCES];

  bank_result_t expected_results [$];
  plan_row_t    plan [$];

  int err_count     = 0;
  int issued        = 0;
  int send_idle_pct = 12;
  int recv_idle_pct = 74;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Remaining need of one table entry; held above claim leaves nothing to ask for.
  function automatic int need_units(int p, int r);
    return (held_units[p][r] > claim_units[p][r]) ? 0 :
           int'(claim_units[p][r]) - int'(held_units[p][r]);
  endfunction

  // Applies one item to the predicted tables and returns the result it should give.
  function automatic bank_result_t judge_item(bank_item_t it);
    bank_result_t res;
    cnt_t         amt [RESOURCES];
    int           work [RESOURCES];
    bit           finished [PROCS];
    int           slot;
    int           p;
    int           r;
    int           pass;
    int           q;
    bit           fits;
    bit           all_done;
    res.status     = ST_LOAD_DONE;
    res.safe_order = '0;
    case (it.mode) inside
      MODE_CLAIM, MODE_HELD: begin
        if (it.process < PROCS && it.resource < RESOURCES) begin
          if (it.mode == MODE_CLAIM) claim_units[it.process][it.resource] = it.value;
          else held_units[it.process][it.resource] = it.value;
        end
      end
      MODE_AVAIL: begin
        if (it.resource < RESOURCES) pool_units[it.resource] = it.value;
      end
      default: begin
        if (it.process >= PROCS) begin
          res.status = ST_EXCEEDS;
          return res;
        end
        p = it.process;
        for (r = 0; r < RESOURCES; r++)
          amt[r] = (r == 0) ? it.req_first : (r == 1) ? it.req_second :
                   (r == 2) ? it.req_third : '0;

        // Claim test before availability test, resource by resource.
        for (r = 0; r < RESOURCES; r++) begin
          if (amt[r] > need_units(p, r)) begin
            res.status = ST_EXCEEDS;
            return res;
          end
          if (amt[r] > pool_units[r]) begin
            res.status = ST_NOT_AVAIL;
            return res;
          end
        end

        // Tentative grant.
        for (r = 0; r < RESOURCES; r++) begin
          pool_units[r]    = pool_units[r] - amt[r];
          held_units[p][r] = held_units[p][r] + amt[r];
        end

        // Safety scan on a working copy with saturating adds.
        for (r = 0; r < RESOURCES; r++) work[r] = pool_units[r];
        for (q = 0; q < PROCS; q++) finished[q] = 1'b0;
        slot = 0;
        for (pass = 0; pass < PROCS; pass++) begin
          for (q = 0; q < PROCS; q++) begin
            fits = !finished[q];
            for (r = 0; r < RESOURCES; r++)
              if (need_units(q, r) > work[r]) fits = 1'b0;
            if (fits) begin
              for (r = 0; r < RESOURCES; r++) begin
                work[r] = work[r] + held_units[q][r];
                if (work[r] > 255) work[r] = 255;
              end
              finished[q] = 1'b1;
              if (slot < ORDER_SLOTS) res.safe_order[3*slot +: 3] = 3'(q);
              slot++;
            end
          end
        end

        all_done = 1'b1;
        for (q = 0; q < PROCS; q++)
          if (!finished[q]) all_done = 1'b0;
        if (all_done) begin
          res.status = ST_GRANTED;
        end else begin
          for (r = 0; r < RESOURCES; r++) begin
            pool_units[r]    = pool_units[r] + amt[r];
            held_units[p][r] = held_units[p][r] - amt[r];
          end
          res.status     = ST_UNSAFE;
          res.safe_order = '0;
        end
      end
    endcase
    return res;
  endfunction

  function automatic bank_item_t make_item(mode_t m, int p, int r, int v, int a, int b, int c);
    bank_item_t it;
    it.mode       = m;
    it.process    = 3'(p);
    it.resource   = 2'(r);
    it.value      = cnt_t'(v);
    it.req_first  = cnt_t'(a);
    it.req_second = cnt_t'(b);
    it.req_third  = cnt_t'(c);
    return it;
  endfunction

  function automatic void add_row(mode_t m, int p, int r, int v, int a, int b, int c,
                                  bit fixed, status_t st, int order);
    plan_row_t row;
    row.item            = make_item(m, p, r, v, a, b, c);
    row.fixed           = fixed;
    row.want.status     = st;
    row.want.safe_order = ORDER_W'(order);
    plan.push_back(row);
  endfunction

  // Request amount for one resource: mostly within need and pool, sometimes beyond.
  function automatic int pick_amount(int p, int r);
    int need;
    int lim;
    int x;
    need = (p < PROCS) ? need_units(p, r) : 0;
    lim  = (need < pool_units[r]) ? need : pool_units[r];
    x    = $urandom_range(0, 99);
    if (x < 70) return $urandom_range(0, lim);
    if (x < 85) return $urandom_range(0, need + 2);
    return $urandom_range(0, 255);
  endfunction

  // Drives one item, waits for its transaction and records the expected result.
  task automatic offer_item(input bank_item_t it, input bit fixed, input bank_result_t fixed_res);
    bank_result_t want;
    bit           ignored;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= it.mode;
    in_ch.process    <= it.process;
    in_ch.resource   <= it.resource;
    in_ch.value      <= it.value;
    in_ch.req_first  <= it.req_first;
    in_ch.req_second <= it.req_second;
    in_ch.req_third  <= it.req_third;
    do @(posedge clk); while (!in_ch.ready);
    want = judge_item(it);
    expected_results.push_back(fixed ? fixed_res : want);
    ignored = (it.mode == MODE_AVAIL) ? (it.resource >= RESOURCES) :
              (it.mode != MODE_REQUEST && (it.process >= PROCS || it.resource >= RESOURCES));
    if (!ignored) issued++;
  endtask

  // Rewrites every table entry with mostly small values, held mostly within claim.
  task automatic load_scene();
    bank_result_t none;
    int           cv;
    int           hv;
    none = '0;
    for (int p = 0; p < PROCS; p++) begin
      for (int r = 0; r < RESOURCES; r++) begin
        cv = ($urandom_range(0, 19) == 0) ? 255 : $urandom_range(0, 8);
        hv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(0, cv);
        offer_item(make_item(MODE_CLAIM, p, r, cv, 0, 0, 0), 1'b0, none);
        offer_item(make_item(MODE_HELD, p, r, hv, 0, 0, 0), 1'b0, none);
      end
    end
    for (int r = 0; r < RESOURCES; r++)
      offer_item(make_item(MODE_AVAIL, 0, r,
                           ($urandom_range(0, 19) == 0) ? 255 : $urandom_range(0, 6),
                           0, 0, 0), 1'b0, none);
  endtask

  // Stimulus: reset, directed table, then random traffic in three idling phases.
  initial begin
    bank_item_t   it;
    bank_result_t none;
    int           kind;
    int           p;
    int           since_scene;
    none = '0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= MODE_CLAIM;
    in_ch.process    <= '0;
    in_ch.resource   <= '0;
    in_ch.value      <= '0;
    in_ch.req_first  <= '0;
    in_ch.req_second <= '0;
    in_ch.req_third  <= '0;
    for (int r = 0; r < RESOURCES; r++) pool_units[r] = '0;
    for (int q = 0; q < PROCS; q++)
      for (int r = 0; r < RESOURCES; r++) begin
        claim_units[q][r] = '0;
        held_units[q][r]  = '0;
      end

    // Empty tables: a zero request is safe in index order.
    add_row(MODE_REQUEST, 0, 0, 0, 0, 0, 0, 1, ST_GRANTED, ORDER_BY_INDEX);
    // Processes out of range are refused as exceeding the claim.
    add_row(MODE_REQUEST, 7, 3, 255, 255, 255, 255, 1, ST_EXCEEDS, 0);
    add_row(MODE_REQUEST, 5, 0, 0, 0, 0, 0, 1, ST_EXCEEDS, 0);
    // Loads with indexes out of range write nothing.
    add_row(MODE_CLAIM, 7, 3, 255, 0, 0, 0, 1, ST_LOAD_DONE, 0);
    add_row(MODE_HELD, 5, 0, 255, 0, 0, 0, 1, ST_LOAD_DONE, 0);
    add_row(MODE_AVAIL, 7, 3, 170, 0, 0, 0, 1, ST_LOAD_DONE, 0);
    // Full pool and full claim for process 0, then take it all.
    for (int r = 0; r < RESOURCES; r++)
      add_row(MODE_AVAIL, 0, r, 255, 0, 0, 0, 1, ST_LOAD_DONE, 0);
    for (int r = 0; r < RESOURCES; r++)
      add_row(MODE_CLAIM, 0, r, 255, 0, 0, 0, 1, ST_LOAD_DONE, 0);
    add_row(MODE_REQUEST, 0, 0, 0, 255, 255, 255, 0, ST_LOAD_DONE, 0);
    add_row(MODE_REQUEST, 0, 0, 0, 1, 0, 0, 1, ST_EXCEEDS, 0);
    // Held above claim for process 1, and a need for process 0 that cannot be met.
    add_row(MODE_HELD, 0, 0, 0, 0, 0, 0, 1, ST_LOAD_DONE, 0);
    add_row(MODE_HELD, 1, 0, 200, 0, 0, 0, 1, ST_LOAD_DONE, 0);
    add_row(MODE_AVAIL, 0, 0, 5, 0, 0, 0, 1, ST_LOAD_DONE, 0);
    add_row(MODE_REQUEST, 1, 0, 0, 0, 0, 0, 0, ST_LOAD_DONE, 0);
    // Working units saturate and process 0 finishes on the second pass.
    add_row(MODE_HELD, 2, 0, 100, 0, 0, 0, 1, ST_LOAD_DONE, 0);
    add_row(MODE_REQUEST, 1, 0, 0, 0, 0, 0, 0, ST_LOAD_DONE, 0);
    // Within claim but beyond the pool, then beyond both.
    add_row(MODE_CLAIM, 3, 1, 50, 0, 0, 0, 1, ST_LOAD_DONE, 0);
    add_row(MODE_REQUEST, 3, 0, 0, 0, 10, 0, 1, ST_NOT_AVAIL, 0);
    add_row(MODE_REQUEST, 3, 0, 0, 0, 60, 0, 1, ST_EXCEEDS, 0);
    add_row(MODE_REQUEST, 4, 0, 0, 0, 0, 255, 1, ST_EXCEEDS, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) offer_item(plan[i].item, plan[i].fixed, plan[i].want);

    // Random traffic: table refreshes, requests shaped by the predicted need, and noise.
    since_scene = 90;
    while (issued < TOTAL_ITEMS) begin
      if (issued < 600) begin
        send_idle_pct = 12;
        recv_idle_pct = 74;
      end else if (issued < 1200) begin
        send_idle_pct = 74;
        recv_idle_pct = 12;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (since_scene >= 90) begin
        load_scene();
        since_scene = 0;
      end
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        it = make_item(mode_t'($urandom_range(0, 3)), $urandom_range(0, 7),
                       $urandom_range(0, 3), $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255));
      end else if (kind < 30) begin
        it = make_item(mode_t'($urandom_range(0, 2)),
                       ($urandom_range(0, 15) == 0) ? $urandom_range(0, 7) :
                                                      $urandom_range(0, PROCS - 1),
                       ($urandom_range(0, 15) == 0) ? 3 : $urandom_range(0, RESOURCES - 1),
                       ($urandom_range(0, 9) == 0) ? 255 :
                       ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) :
                                                     $urandom_range(0, 12),
                       0, 0, 0);
      end else begin
        p = ($urandom_range(0, 15) == 0) ? $urandom_range(PROCS, 7) :
                                           $urandom_range(0, PROCS - 1);
        it = make_item(MODE_REQUEST, p, $urandom_range(0, 3), $urandom_range(0, 255),
                       pick_amount(p, 0), pick_amount(p, 1), pick_amount(p, 2));
      end
      offer_item(it, 1'b0, none);
      since_scene++;
    end
    in_ch.valid <= 1'b0;

    // Drain the outstanding results, then allow one more item's latency.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Result side: random stalls and comparison of each transaction with the oldest expectation.
  initial begin
    bank_result_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d safe_order 'h%0h",
                 out_ch.status, out_ch.safe_order);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_ch.status);
            err_count++;
          end
          if (out_ch.safe_order !== want.safe_order) begin
            $error("safe_order: expected 'h%0h, actual 'h%0h",
                   want.safe_order, out_ch.safe_order);
            err_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog against a hung handshake.
  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> files.f
design/brsc_pkg.sv
design/brsc_in_if.sv
design/brsc_out_if.sv
design/brsc_useq.sv
design/bankers_request_safety_check.sv
tb/sv/tb_bankers_request_safety_check.sv
